### src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");

`endif

### src/bpps_pkg.sv
`default_nettype none
package bpps_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLUMNS = 128;
    localparam int PAGE_COUNT  = (MAX_ROWS + 7) / 8;
    localparam int STORE_DEPTH = PAGE_COUNT * MAX_COLUMNS;
    localparam int PAGE_W      = $clog2(PAGE_COUNT);
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int CMD_BYTES = 3;

    // Field widths
    localparam int MODE_W  = 2;
    localparam int ROW_W   = 6;
    localparam int PCOL_W  = 7;
    localparam int ROWS_W  = 7;
    localparam int COLS_W  = 8;
    localparam int BYTE_W  = 8;
    localparam int CFGI_W  = 2;
    localparam int CFGD_W  = 8;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    // Register indexes
    localparam logic [CFGI_W-1:0] CFG_ROWS   = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_COLS   = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_INVERT = 2'd2;

    // Register reset values
    localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd60;
    localparam logic [COLS_W-1:0] COLS_RESET = 8'd80;

    // Display commands
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic clear;     // clearing pass, write zero at sweep address
        logic capture;   // latch the incoming word
        logic mem_read;  // read the store for the latched word
        logic finish;    // apply the word, load the output register
    } t_cmd;

    typedef struct packed {
        logic clear_last; // sweep is at the last entry
        logic out_free;   // output register can take a result
    } t_sts;

endpackage
`default_nettype wire

### src/bpps_ctrl.sv
`default_nettype none
module bpps_ctrl
    import bpps_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_READ: begin
                o_cmd.mem_read = 1'b1;
            end
            S_FINISH: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

### src/bpps_dpath.sv
`default_nettype none
module bpps_dpath
    import bpps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    // input word
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic [ROW_W-1:0]  i_pixel_row,
    input  wire logic [PCOL_W-1:0] i_pixel_column,
    input  wire logic              i_pixel_value,
    // register writes
    input  wire logic              i_cfg_we,
    input  wire logic [CFGI_W-1:0] i_cfg_index,
    input  wire logic [CFGD_W-1:0] i_cfg_data,
    // result word
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_bit_valid,
    output logic                   o_serial_bit,
    output logic                   o_data_not_command,
    output logic                   o_byte_done,
    output logic                   o_frame_done,
    output logic                   o_busy_res,
    output logic                   o_write_ignored
);

    // latched word
    logic [MODE_W-1:0] r_mode;
    logic [ROW_W-1:0]  r_row;
    logic [PCOL_W-1:0] r_col;
    logic              r_val;

    // registers
    logic [ROWS_W-1:0] r_rows;
    logic [COLS_W-1:0] r_cols;
    logic              r_inv;

    // refresh state
    logic [PAGE_W-1:0] r_page, n_page;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic [2:0]        r_bit, n_bit;
    logic [7:0]        r_shift, n_shift;
    logic              r_refreshing, n_refreshing;

    // store
    logic [7:0]        r_mem [STORE_DEPTH];
    logic [7:0]        r_rd_data;
    logic [ADDR_W-1:0] r_clr_addr;

    // result
    logic r_out_valid;
    logic r_bit_valid, n_bit_valid;
    logic r_sbit, n_sbit;
    logic r_dnc, n_dnc;
    logic r_bdone, n_bdone;
    logic r_fdone, n_fdone;
    logic r_busy, n_busy;
    logic r_ign, n_ign;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [7:0]        mem_wd;
    logic [ADDR_W-1:0] mem_ra;

    logic [ROWS_W-1:0] rows_eff;
    logic [COLS_W-1:0] cols_eff;
    logic [PAGE_W-1:0] pix_page;
    logic              pix_in_range;
    logic [ADDR_W-1:0] pix_addr;
    logic [7:0]        pix_mask;
    logic [BYTE_W-1:0] col_off;
    logic [ROWS_W-1:0] first_row;
    logic [ROWS_W-1:0] row_rem;
    logic [7:0]        row_mask;
    logic [7:0]        data_byte;
    logic [7:0]        cur_byte;
    logic [7:0]        tx_byte;
    logic [BYTE_W:0]   byte_next;
    logic [BYTE_W:0]   byte_limit;
    logic [PAGE_W:0]   page_next;
    logic [PAGE_W:0]   page_limit;
    logic [ROWS_W:0]   rows_plus;
    logic              out_free;

    // saturated registers
    always_comb begin
        rows_eff = r_rows;
        if (r_rows == '0) rows_eff = ROWS_W'(1);
        if (r_rows > ROWS_W'(MAX_ROWS)) rows_eff = ROWS_W'(MAX_ROWS);
        cols_eff = r_cols;
        if (r_cols == '0) cols_eff = COLS_W'(1);
        if (r_cols > COLS_W'(MAX_COLUMNS)) cols_eff = COLS_W'(MAX_COLUMNS);
    end

    assign pix_page     = PAGE_W'(r_row >> 3);
    assign pix_in_range = (32'(r_row) < MAX_ROWS) && (32'(r_col) < MAX_COLUMNS);
    assign pix_addr     = {pix_page, COL_W'(r_col)};
    assign pix_mask     = 8'd1 << r_row[2:0];
    assign col_off      = r_byte - BYTE_W'(CMD_BYTES);

    assign mem_ra = (r_mode == MODE_TICK) ? {r_page, col_off[COL_W-1:0]} : pix_addr;

    // row masking of a data byte
    assign first_row = ROWS_W'({r_page, 3'b000});
    assign row_rem   = rows_eff - first_row;
    always_comb begin
        if (rows_eff >= first_row + ROWS_W'(8)) begin
            row_mask = 8'hFF;
        end else if (rows_eff > first_row) begin
            row_mask = (8'd1 << row_rem[2:0]) - 8'd1;
        end else begin
            row_mask = 8'h00;
        end
    end
    assign data_byte = (r_rd_data & row_mask) ^ {8{r_inv}};

    always_comb begin
        case (r_byte)
            BYTE_W'(0): cur_byte = CMD_PAGE_BASE + 8'(r_page);
            BYTE_W'(1): cur_byte = CMD_COL_HIGH;
            BYTE_W'(2): cur_byte = CMD_COL_LOW;
            default:    cur_byte = data_byte;
        endcase
    end

    assign tx_byte    = (r_bit == 3'd0) ? cur_byte : r_shift;
    assign byte_next  = {1'b0, r_byte} + (BYTE_W+1)'(1);
    assign byte_limit = (BYTE_W+1)'(CMD_BYTES) + (BYTE_W+1)'(cols_eff);
    assign page_next  = {1'b0, r_page} + (PAGE_W+1)'(1);
    assign rows_plus  = {1'b0, rows_eff} + (ROWS_W+1)'(7);
    assign page_limit = (PAGE_W+1)'(rows_plus >> 3);

    assign out_free = !r_out_valid || i_out_ready;

    // apply the latched word
    always_comb begin
        n_page       = r_page;
        n_byte       = r_byte;
        n_bit        = r_bit;
        n_shift      = r_shift;
        n_refreshing = r_refreshing;
        n_bit_valid  = 1'b0;
        n_sbit       = 1'b0;
        n_dnc        = 1'b0;
        n_bdone      = 1'b0;
        n_fdone      = 1'b0;
        n_ign        = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = pix_addr;
        mem_wd       = r_val ? (r_rd_data | pix_mask) : (r_rd_data & ~pix_mask);
        if (i_cmd.clear) begin
            mem_we = 1'b1;
            mem_wa = r_clr_addr;
            mem_wd = 8'h00;
        end else if (i_cmd.finish) begin
            unique case (r_mode)
                MODE_WRITE: begin
                    if (r_refreshing) begin
                        n_ign = 1'b1;
                    end else begin
                        mem_we = pix_in_range;
                    end
                end
                MODE_START: begin
                    if (r_refreshing) begin
                        n_ign = 1'b1;
                    end else begin
                        n_refreshing = 1'b1;
                        n_page       = '0;
                        n_byte       = '0;
                        n_bit        = '0;
                        n_shift      = '0;
                    end
                end
                MODE_TICK: begin
                    if (r_refreshing) begin
                        n_bit_valid = 1'b1;
                        n_sbit      = tx_byte[7];
                        n_dnc       = (r_byte >= BYTE_W'(CMD_BYTES));
                        n_shift     = {tx_byte[6:0], 1'b0};
                        if (r_bit == 3'd7) begin
                            n_bdone = 1'b1;
                            n_bit   = '0;
                            n_byte  = byte_next[BYTE_W-1:0];
                            if (byte_next >= byte_limit) begin
                                n_byte = '0;
                                n_page = page_next[PAGE_W-1:0];
                                if (page_next >= page_limit) begin
                                    n_page       = '0;
                                    n_refreshing = 1'b0;
                                    n_fdone      = 1'b1;
                                end
                            end
                        end else begin
                            n_bit = r_bit + 3'd1;
                        end
                    end
                end
                default: begin
                    n_ign = 1'b0;
                end
            endcase
        end
        n_busy = n_refreshing;
    end

    // store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (i_cmd.mem_read) r_rd_data <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_row  <= i_pixel_row;
            r_col  <= i_pixel_column;
            r_val  <= i_pixel_value;
        end
        if (i_cmd.finish) begin
            r_bit_valid <= n_bit_valid;
            r_sbit      <= n_sbit;
            r_dnc       <= n_dnc;
            r_bdone     <= n_bdone;
            r_fdone     <= n_fdone;
            r_busy      <= n_busy;
            r_ign       <= n_ign;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows       <= ROWS_RESET;
            r_cols       <= COLS_RESET;
            r_inv        <= 1'b0;
            r_page       <= '0;
            r_byte       <= '0;
            r_bit        <= '0;
            r_shift      <= '0;
            r_refreshing <= 1'b0;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ROWS:   r_rows <= i_cfg_data[ROWS_W-1:0];
                    CFG_COLS:   r_cols <= i_cfg_data[COLS_W-1:0];
                    CFG_INVERT: r_inv  <= i_cfg_data[0];
                    default:    r_inv  <= r_inv;
                endcase
            end
            r_page       <= n_page;
            r_byte       <= n_byte;
            r_bit        <= n_bit;
            r_shift      <= n_shift;
            r_refreshing <= n_refreshing;
            if (i_cmd.clear) r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clear_last = (r_clr_addr == ADDR_W'(STORE_DEPTH - 1));
    assign o_sts.out_free   = out_free;

    assign o_out_valid        = r_out_valid;
    assign o_bit_valid        = r_bit_valid;
    assign o_serial_bit       = r_sbit;
    assign o_data_not_command = r_dnc;
    assign o_byte_done        = r_bdone;
    assign o_frame_done       = r_fdone;
    assign o_busy_res         = r_busy;
    assign o_write_ignored    = r_ign;

endmodule
`default_nettype wire

### src/bitmap_page_pack_serial_refresh.sv
`default_nettype none
// Page-packed one-bit frame buffer with a serial refresh engine. Pixels are
// written one at a time into a 1024-byte store (eight pages of eight rows by
// 128 columns, bit k of a byte is row 8*page+k). A start word begins a refresh;
// each tick word then drives one serial bit, MSB first: per page the commands
// 0xB0+page, 0x10, 0x00 and then one data byte per column sent, rows past
// rows_in_use masked to zero, data optionally inverted. Every input word gives
// exactly one result word. After reset the block runs a clearing pass over the
// store, during which no input word is taken (register writes are). A word passes
// from acceptance to result through capture, store read and update, the read
// step set by the registered read of the store; the result sits in an output
// register, and a new word is taken only after the update, which waits while the
// output register still holds an unaccepted result. Register writes are always
// ready and take effect at once.
module bitmap_page_pack_serial_refresh
    import bpps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input words
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [15:0]       i_s_axis_tdata,  // pixel_row[5:0], pixel_column[12:6],
                                                    // pixel_value[13], zero[15:14]
    input  wire logic [MODE_W-1:0] i_s_axis_tuser,  // mode[1:0]
    // result words
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic [7:0]             o_m_axis_tdata,  // bit_valid[0], serial_bit[1],
                                                    // byte_done[2], busy_res[3],
                                                    // write_ignored[4], zero[7:5]
    output logic [0:0]             o_m_axis_tuser,  // data_not_command[0]
    output logic                   o_m_axis_tlast,  // frame_done
    // register writes
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFGI_W-1:0] i_cfg_index,
    input  wire logic [CFGD_W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    t_cmd cmd;
    t_sts sts;

    logic bit_valid, serial_bit, dnc, byte_done, frame_done, busy_res, write_ignored;

    assign o_cfg_ready = 1'b1;

    // sequencer: clear sweep, capture, read, update
    bpps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // store, refresh counters, registers, output register
    bpps_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_mode             (i_s_axis_tuser),
        .i_pixel_row        (i_s_axis_tdata[5:0]),
        .i_pixel_column     (i_s_axis_tdata[12:6]),
        .i_pixel_value      (i_s_axis_tdata[13]),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_out_valid        (o_m_axis_tvalid),
        .i_out_ready        (i_m_axis_tready),
        .o_bit_valid        (bit_valid),
        .o_serial_bit       (serial_bit),
        .o_data_not_command (dnc),
        .o_byte_done        (byte_done),
        .o_frame_done       (frame_done),
        .o_busy_res         (busy_res),
        .o_write_ignored    (write_ignored)
    );

    assign o_m_axis_tdata = {3'b000, write_ignored, busy_res, byte_done, serial_bit, bit_valid};
    assign o_m_axis_tuser = dnc;
    assign o_m_axis_tlast = frame_done;

    // end of frame only on the last bit of a byte
    `ASSERT_IMPL(a_frame_on_byte, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast, o_m_axis_tdata[0] && o_m_axis_tdata[2] && !o_m_axis_tdata[3])
    // a dropped write never drives a bit
    `ASSERT_IMPL(a_ign_no_bit, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[4], !o_m_axis_tdata[0])
    // one word in flight: no accept right after an accept
    `ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    // an update never overwrites a result that is still held
    `ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, cmd.finish && o_m_axis_tvalid, i_m_axis_tready)

endmodule
`default_nettype wire
